### sv/polyval_gf128_hash_assert.svh
// Assertion macros used by the checker of the POLYVAL hash block.
`ifndef POLYVAL_GF128_HASH_ASSERT_SVH
`define POLYVAL_GF128_HASH_ASSERT_SVH

// Implication in the same cycle, sampled on the rising clock edge.
`define PVH_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("polyval hash assertion failed");

// Implication in the following cycle.
`define PVH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("polyval hash assertion failed");

`endif

### sv/pvh_pkg.sv
// Types, constants and carry-less arithmetic for the POLYVAL hash block.
package pvh_pkg;

   localparam int HalfWidth   = 64;
   localparam int BlockWidth  = 2 * HalfWidth;
   localparam int DigitWidth  = 32;
   localparam int DigitCount  = BlockWidth / DigitWidth;
   localparam int CountWidth  = $clog2(DigitCount);
   localparam int PartWidth   = BlockWidth + DigitWidth;

   localparam logic [HalfWidth-1:0]  FoldConst = 64'hc200000000000000;
   localparam logic [CountWidth-1:0] DigitLast = CountWidth'(DigitCount - 1);

   localparam logic CsrKeyLow  = 1'b0;
   localparam logic CsrKeyHigh = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [BlockWidth-1:0] high;
      logic [BlockWidth-1:0] low;
   } prod_type;

   // Carry-less product of a full block and one key digit.
   function automatic logic [PartWidth-1:0] clmul_digit(
      input logic [BlockWidth-1:0] a,
      input logic [DigitWidth-1:0] d
   );
      logic [PartWidth-1:0] r;
      r = '0;
      for (int i = 0; i < DigitWidth; i++) begin
         if (d[i]) begin
            r = r ^ ({{DigitWidth{1'b0}}, a} << i);
         end
      end
      return r;
   endfunction

   // Carry-less 64 by 64 product; used only with the constant fold operand.
   function automatic logic [BlockWidth-1:0] clmul64(
      input logic [HalfWidth-1:0] a,
      input logic [HalfWidth-1:0] b
   );
      logic [BlockWidth-1:0] r;
      r = '0;
      for (int i = 0; i < HalfWidth; i++) begin
         if (b[i]) begin
            r = r ^ ({{HalfWidth{1'b0}}, a} << i);
         end
      end
      return r;
   endfunction

   // One Montgomery folding step on the low two quarters of the product.
   function automatic logic [BlockWidth-1:0] fold_step(input logic [BlockWidth-1:0] w);
      logic [BlockWidth-1:0] f;
      f = clmul64(FoldConst, w[HalfWidth-1:0]);
      return {f[BlockWidth-1:HalfWidth] ^ w[HalfWidth-1:0],
              f[HalfWidth-1:0] ^ w[BlockWidth-1:HalfWidth]};
   endfunction

   // Reduces a 256-bit carry-less product to a * b * x^-128.
   function automatic logic [BlockWidth-1:0] reduce(input prod_type p);
      logic [BlockWidth-1:0] w;
      w = fold_step(fold_step(p.low));
      return p.high ^ w;
   endfunction

endpackage

### sv/pvh_mul.sv
// Digit-serial carry-less multiplier: one 32-bit key digit per cycle, low digit first.
module pvh_mul
   import pvh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [BlockWidth-1:0] cur,
   input  logic [BlockWidth-1:0] key,
   output logic                  done,
   output prod_type              prod
);

   logic                  run_ff, run_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic [BlockWidth-1:0] cur_ff, cur_in;
   logic [BlockWidth-1:0] key_ff, key_in;
   logic [BlockWidth-1:0] hi_ff, hi_in;
   logic [BlockWidth-1:0] lo_ff, lo_in;
   logic [PartWidth-1:0]  step;

   always_comb begin
      step   = {{DigitWidth{1'b0}}, hi_ff} ^ clmul_digit(cur_ff, key_ff[DigitWidth-1:0]);
      run_in = run_ff;
      cnt_in = cnt_ff;
      cur_in = cur_ff;
      key_in = key_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      if (load) begin
         run_in = 1'b1;
         cnt_in = '0;
         cur_in = cur;
         key_in = key;
         hi_in  = '0;
      end else if (run_ff) begin
         cnt_in = cnt_ff + CountWidth'(1);
         key_in = key_ff >> DigitWidth;
         hi_in  = step[PartWidth-1:DigitWidth];
         lo_in  = {step[DigitWidth-1:0], lo_ff[BlockWidth-1:DigitWidth]};
         if (cnt_ff == DigitLast) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      cur_ff <= cur_in;
      key_ff <= key_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   assign done      = run_ff && (cnt_ff == DigitLast);
   assign prod.high = hi_ff;
   assign prod.low  = lo_ff;

endmodule

### sv/polyval_gf128_hash.sv
// Top level of the POLYVAL hash: handshake control, accumulator, key and result register.
//
// A request transaction carries one 128-bit block on req_tdata and the start flag on
// req_tuser; a set flag clears the accumulator before the block is absorbed. Each block
// gives one response transaction with the updated accumulator on rsp_tdata.
// The user writes the hash key through csr_we, csr_index and csr_wdata while the block is
// idle; the block itself does not enforce this. The product is formed by a carry-less
// multiplier that takes one 32-bit key digit per cycle; reduction and the accumulator
// update follow. A response is valid once its result is stored, and a new request is
// accepted in the same cycle in which the previous result is stored. The result sits in
// an output register, so a request may be accepted while an earlier response still waits;
// if the receiver stalls, the following block stops after its multiply until the output
// register is free. Reset clears the accumulator, the key and all handshake state.
module polyval_gf128_hash
   import pvh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BlockWidth-1:0] req_tdata,   // block_low, block_high
   input  logic                  req_tuser,   // start_new
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [BlockWidth-1:0] rsp_tdata,   // digest_low, digest_high
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [HalfWidth-1:0]  csr_wdata
);

   state_type             state_ff, state_in;
   logic [BlockWidth-1:0] acc_ff, acc_in;
   logic [HalfWidth-1:0]  key_lo_ff, key_lo_in;
   logic [HalfWidth-1:0]  key_hi_ff, key_hi_in;
   logic [BlockWidth-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;
   logic                  out_free;
   logic                  write;
   logic                  mul_done;
   prod_type              prod;
   logic [BlockWidth-1:0] result;
   logic [BlockWidth-1:0] acc_base;
   logic [BlockWidth-1:0] cur;

   pvh_mul u_mul (
      .clock (clock),
      .reset (reset),
      .load  (accept),
      .cur   (cur),
      .key   ({key_hi_ff, key_lo_ff}),
      .done  (mul_done),
      .prod  (prod)
   );

   assign result   = reduce(prod);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      write      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               write      = 1'b1;
               req_tready = 1'b1;
               state_in   = req_tvalid ? ST_MUL : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      acc_base     = write ? result : acc_ff;
      cur          = (req_tuser ? '0 : acc_base) ^ req_tdata;
      acc_in       = acc_base;
      rsp_data_in  = write ? result : rsp_data_ff;
      rsp_valid_in = write || (rsp_valid_ff && !rsp_tready);
      key_lo_in    = key_lo_ff;
      key_hi_in    = key_hi_ff;
      if (csr_we) begin
         case (csr_index)
            CsrKeyLow:  key_lo_in = csr_wdata;
            CsrKeyHigh: key_hi_in = csr_wdata;
            default:    key_lo_in = key_lo_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         key_lo_ff    <= '0;
         key_hi_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         key_lo_ff    <= key_lo_in;
         key_hi_ff    <= key_hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### sv/pvh_checker.sv
// Port-level checker for the POLYVAL hash block, bound to the top level.
`include "polyval_gf128_hash_assert.svh"

module pvh_checker
   import pvh_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [BlockWidth-1:0] rsp_tdata
);

   logic req_accept;

   assign req_accept = req_tvalid && req_tready;

   `PVH_ASSERT_NEXT(rsp_hold_a, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `PVH_ASSERT_NEXT(req_gap_a, req_accept, !req_tready)
   `PVH_ASSERT_SAME(req_busy_a, req_accept, ##4 !req_tready)

endmodule

bind polyval_gf128_hash pvh_checker u_pvh_checker (.*);

### sim/polyval_gf128_hash_tb.sv
// Self-checking testbench for the POLYVAL hash block: directed key and block cases, then random streams.
`timescale 1ns / 1ps

module polyval_gf128_hash_tb
   import pvh_pkg::*;
;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BlockWidth-1:0] req_tdata = '0;   // block_low, block_high
   logic                  req_tuser = 1'b0;  // start_new
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [BlockWidth-1:0] rsp_tdata;        // digest_low, digest_high
   logic                  csr_we = 1'b0;
   logic                  csr_index = CsrKeyLow;
   logic [HalfWidth-1:0]  csr_wdata = '0;

   logic [BlockWidth-1:0] key_model = '0;
   logic [BlockWidth-1:0] acc_model = '0;
   logic [BlockWidth-1:0] digest_q[$];
   logic [BlockWidth-1:0] digest_exp;
   int                    mismatch_count = 0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;

   polyval_gf128_hash dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Field product a * b * x^-128: full carry-less product, then two folds of the low half.
   function automatic logic [BlockWidth-1:0] polyval_mul(input logic [BlockWidth-1:0] a,
                                                          input logic [BlockWidth-1:0] b);
      logic [2*BlockWidth-1:0] prod;
      logic [BlockWidth-1:0]   fold;
      logic [BlockWidth-1:0]   w;
      prod = '0;
      for (int i = 0; i < BlockWidth; i++) begin
         if (b[i]) begin
            prod = prod ^ ({{BlockWidth{1'b0}}, a} << i);
         end
      end
      w = prod[BlockWidth-1:0];
      repeat (2) begin
         fold = '0;
         for (int i = 0; i < HalfWidth; i++) begin
            if (w[i]) begin
               fold = fold ^ ({{HalfWidth{1'b0}}, FoldConst} << i);
            end
         end
         w = {fold[BlockWidth-1:HalfWidth] ^ w[HalfWidth-1:0],
              fold[HalfWidth-1:0] ^ w[BlockWidth-1:HalfWidth]};
      end
      return prod[2*BlockWidth-1:BlockWidth] ^ w;
   endfunction

   function automatic logic [HalfWidth-1:0] random_half();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [BlockWidth-1:0] random_key();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 128'd1 << $urandom_range(127);
         default: return {random_half(), random_half()};
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_q.size() == 0) begin
            $display("%0t: digest with none expected, actual %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            digest_exp = digest_q.pop_front();
            if (rsp_tdata[HalfWidth-1:0] !== digest_exp[HalfWidth-1:0]) begin
               $display("%0t: digest_low expected %h actual %h", $time,
                        digest_exp[HalfWidth-1:0], rsp_tdata[HalfWidth-1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[BlockWidth-1:HalfWidth] !== digest_exp[BlockWidth-1:HalfWidth]) begin
               $display("%0t: digest_high expected %h actual %h", $time,
                        digest_exp[BlockWidth-1:HalfWidth], rsp_tdata[BlockWidth-1:HalfWidth]);
               mismatch_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic absorb_block(input logic [HalfWidth-1:0] lo, input logic [HalfWidth-1:0] hi,
                               input logic start);
      logic [BlockWidth-1:0] state_in;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {hi, lo};
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      state_in  = (start ? '0 : acc_model) ^ {hi, lo};
      acc_model = polyval_mul(state_in, key_model);
      digest_q.push_back(acc_model);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_key(input logic [BlockWidth-1:0] k);
      csr_we    <= 1'b1;
      csr_index <= CsrKeyLow;
      csr_wdata <= k[HalfWidth-1:0];
      @(posedge clock);
      csr_index <= CsrKeyHigh;
      csr_wdata <= k[BlockWidth-1:HalfWidth];
      @(posedge clock);
      csr_we    <= 1'b0;
      key_model = k;
   endtask

   task automatic test_reset_defaults();
      absorb_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      absorb_block('1, '1, 1'b1);
   endtask

   task automatic test_key_extremes();
      logic [BlockWidth-1:0] keys[4];
      keys = '{'1, 128'd1, 128'd1 << 127, {64'd0, 64'hffff_ffff_ffff_ffff}};
      foreach (keys[i]) begin
         wait_idle();
         load_key(keys[i]);
         absorb_block('0, '0, 1'b1);
         absorb_block('1, '1, 1'b0);
         absorb_block('1, 64'h8000_0000_0000_0000, 1'b1);
      end
   endtask

   task automatic test_key_change();
      wait_idle();
      load_key({64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210});
      absorb_block(64'h1, '0, 1'b1);
      absorb_block('0, 64'h1, 1'b0);
      wait_idle();
      load_key({64'h8000_0000_0000_0001, 64'h5555_aaaa_5555_aaaa});
      absorb_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      absorb_block('0, '0, 1'b0);
      absorb_block('1, '0, 1'b1);
   endtask

   task automatic test_random_stream(input int count, input int send_pct, input int recv_pct);
      int sent;
      int run_len;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(7) == 0) begin
            wait_idle();
            load_key(random_key());
         end
         run_len = $urandom_range(1, 16);
         for (int i = 0; i < run_len && sent < count; i++) begin
            absorb_block(random_half(), random_half(),
                         (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_key_extremes();
      test_key_change();
      test_random_stream(670, 9, 88);
      test_random_stream(670, 88, 9);
      test_random_stream(670, 0, 0);
      req_tvalid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #1_500_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
